// ===== rtl/bsm3_pkg.sv =====
// Package for the 3x3 box smoothing block: sizes, payload structs, divider constants.
// No dependencies; bsm3_window, bsm3_divide and the top level import it.
`default_nettype none

package bsm3_pkg;

    localparam int MAX_SIZE  = 1024;                 // largest image side
    localparam int SIZE_MIN  = 2;                    // smallest image side
    localparam int CH_W      = 16;                   // bits per color channel
    localparam int SIZE_W    = 11;                   // image_size register width
    localparam int POS_W     = 10;                   // reported row / column width
    localparam int ADDR_W    = $clog2(MAX_SIZE);     // column index width
    localparam int SUM_W     = CH_W + 4;             // sum of up to nine samples
    localparam int DIV_SHIFT = SUM_W + 4;            // reciprocal scaling
    localparam int RECIP_W   = DIV_SHIFT - 1;
    localparam int PROD_W    = SUM_W + RECIP_W;

    // floor(x / d) == (x * ceil(2^DIV_SHIFT / d)) >> DIV_SHIFT for every x below 2^SUM_W
    localparam logic [RECIP_W-1:0] RECIP_4 = RECIP_W'(2 ** (DIV_SHIFT - 2));
    localparam logic [RECIP_W-1:0] RECIP_6 = RECIP_W'((2 ** DIV_SHIFT + 5) / 6);
    localparam logic [RECIP_W-1:0] RECIP_9 = RECIP_W'((2 ** DIV_SHIFT + 8) / 9);

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
    } t_in_pixel;

    typedef struct packed {
        logic [CH_W-1:0]  out_red;
        logic [CH_W-1:0]  out_green;
        logic [CH_W-1:0]  out_blue;
        logic [POS_W-1:0] out_row;
        logic [POS_W-1:0] out_col;
        logic             run_last;
        logic             frame_done;
    } t_result;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    // One line-buffer word: the two rows above the current one at a column
    typedef struct packed {
        t_rgb older;
        t_rgb newer;
    } t_row_pair;

    // Pixel held between acceptance and the window update
    typedef struct packed {
        t_rgb              px;
        logic [ADDR_W-1:0] row;
        logic [ADDR_W-1:0] col;
        logic              emits;     // row >= 1 and col >= 1
        logic              row_last;
        logic              col_last;
        logic              row_ge2;
        logic              col_ge2;
    } t_stage;

    typedef enum logic [1:0] {
        CNT_4,
        CNT_6,
        CNT_9
    } t_count;

    // One pending result: channel sums and the divisor still to apply
    typedef struct packed {
        logic [SUM_W-1:0] sum_red;
        logic [SUM_W-1:0] sum_green;
        logic [SUM_W-1:0] sum_blue;
        t_count           count;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic             run_last;
        logic             frame_done;
    } t_job;

endpackage

`default_nettype wire

// ===== rtl/bsm3_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module bsm3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/bsm3_window.sv =====
// 3x3 window registers, per-pixel result sequencer and region summing stage.
// Depends on bsm3_pkg.
`default_nettype none

module bsm3_window import bsm3_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_s1_valid,
    input  wire t_stage    i_s1,
    input  wire t_row_pair i_rows,
    output logic           o_s1_take,
    output logic           o_job_valid,
    output t_job           o_job,
    input  wire logic      i_job_stall
);

    t_rgb              r_win [3][3];   // [row slot][column slot], slot 2 newest
    logic [3:0]        r_jobs;         // pending results of the held pixel
    logic [ADDR_W-1:0] r_row;
    logic [ADDR_W-1:0] r_col;
    logic              r_row_ge2;
    logic              r_col_ge2;
    logic              r_frame_last;
    logic              r_job_valid;
    t_job              r_job;

    logic              job_load;
    logic              emit;
    logic [3:0]        jobs_left;
    logic [3:0]        cur;
    logic              lower_only;     // rows r-1 .. r only
    logic              right_only;     // columns c-1 .. c only
    logic [CH_W-1:0]   w      [3][3][3];
    logic [SUM_W-1:0]  colsum [3][3];
    logic [SUM_W-1:0]  sums   [3];
    t_job              n_job;

    assign job_load  = !r_job_valid || !i_job_stall;
    assign emit      = (r_jobs != 4'd0) && job_load;
    assign jobs_left = r_jobs & (r_jobs - 4'd1);
    assign cur       = r_jobs & (~r_jobs + 4'd1);
    assign o_s1_take = i_s1_valid && ((r_jobs == 4'd0) || (emit && (jobs_left == 4'd0)));

    // bit 0: (r-1, c-1)  bit 1: (r-1, c)  bit 2: (r, c-1)  bit 3: (r, c)
    assign lower_only = cur[2] || cur[3] || !r_row_ge2;
    assign right_only = cur[1] || cur[3] || !r_col_ge2;

    always_comb begin
        for (int rs = 0; rs < 3; rs++) begin
            for (int cs = 0; cs < 3; cs++) begin
                w[0][rs][cs] = r_win[rs][cs].red;
                w[1][rs][cs] = r_win[rs][cs].green;
                w[2][rs][cs] = r_win[rs][cs].blue;
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            for (int cs = 0; cs < 3; cs++) begin
                colsum[ch][cs] = (lower_only ? SUM_W'(0) : SUM_W'(w[ch][0][cs]))
                               + SUM_W'(w[ch][1][cs]) + SUM_W'(w[ch][2][cs]);
            end
            sums[ch] = (right_only ? SUM_W'(0) : colsum[ch][0])
                     + colsum[ch][1] + colsum[ch][2];
        end
    end

    always_comb begin
        n_job.sum_red    = sums[0];
        n_job.sum_green  = sums[1];
        n_job.sum_blue   = sums[2];
        if (lower_only && right_only) begin
            n_job.count = CNT_4;
        end else if (lower_only || right_only) begin
            n_job.count = CNT_6;
        end else begin
            n_job.count = CNT_9;
        end
        n_job.row        = POS_W'((cur[2] || cur[3]) ? r_row : r_row - ADDR_W'(1));
        n_job.col        = POS_W'((cur[1] || cur[3]) ? r_col : r_col - ADDR_W'(1));
        n_job.run_last   = (jobs_left == 4'd0);
        n_job.frame_done = r_frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jobs      <= 4'd0;
            r_job_valid <= 1'b0;
        end else begin
            if (o_s1_take) begin
                r_jobs <= i_s1.emits ? {i_s1.row_last && i_s1.col_last, i_s1.row_last,
                                        i_s1.col_last, 1'b1} : 4'd0;
            end else if (emit) begin
                r_jobs <= jobs_left;
            end
            if (job_load) begin
                r_job_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s1_take) begin
            for (int rs = 0; rs < 3; rs++) begin
                r_win[rs][0] <= r_win[rs][1];
                r_win[rs][1] <= r_win[rs][2];
            end
            r_win[0][2]  <= i_rows.older;
            r_win[1][2]  <= i_rows.newer;
            r_win[2][2]  <= i_s1.px;
            r_row        <= i_s1.row;
            r_col        <= i_s1.col;
            r_row_ge2    <= i_s1.row_ge2;
            r_col_ge2    <= i_s1.col_ge2;
            r_frame_last <= i_s1.row_last && i_s1.col_last;
        end
        if (emit) begin
            r_job <= n_job;
        end
    end

    assign o_job_valid = r_job_valid;
    assign o_job       = r_job;

endmodule

`default_nettype wire

// ===== rtl/bsm3_divide.sv =====
// Divides channel sums by 4, 6 or 9 through reciprocal multiply; holds the result register.
// Depends on bsm3_pkg.
`default_nettype none

module bsm3_divide import bsm3_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_stall,
    output logic      o_valid,
    output t_result   o_res,
    input  wire logic i_stall
);

    logic               r_valid;
    t_result            r_res;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod [3];
    t_result            n_res;

    always_comb begin
        case (i_job.count)
            CNT_4:   recip = RECIP_4;
            CNT_6:   recip = RECIP_6;
            CNT_9:   recip = RECIP_9;
            default: recip = RECIP_9;
        endcase
    end

    assign prod[0] = PROD_W'(i_job.sum_red)   * PROD_W'(recip);
    assign prod[1] = PROD_W'(i_job.sum_green) * PROD_W'(recip);
    assign prod[2] = PROD_W'(i_job.sum_blue)  * PROD_W'(recip);

    always_comb begin
        n_res.out_red    = prod[0][DIV_SHIFT +: CH_W];
        n_res.out_green  = prod[1][DIV_SHIFT +: CH_W];
        n_res.out_blue   = prod[2][DIV_SHIFT +: CH_W];
        n_res.out_row    = i_job.row;
        n_res.out_col    = i_job.col;
        n_res.run_last   = i_job.run_last;
        n_res.frame_done = i_job.frame_done;
    end

    assign o_job_stall = r_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_job_stall) begin
            r_valid <= i_job_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_job_stall && i_job_valid) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

`default_nettype wire

// ===== rtl/box_smooth_three_by_three_top.sv =====
// Top level of the 3x3 box smoothing filter: position counters, line buffer, pipeline.
// Depends on bsm3_pkg, bsm3_ram, bsm3_window and bsm3_divide.
//
// Usage:
//  - Pixels of a square RGB image enter in raster order on i_pix, one transfer per
//    cycle with i_valid high and o_stall low. Results leave on o_res, one per cycle with
//    o_valid high and i_stall low, in raster order save the interleaved last two rows.
//  - Each result is the truncated per-channel mean of the in-image 3x3 neighbors and
//    carries its row and column; run_last marks the last result released by a pixel,
//    frame_done marks all results released by the final pixel of the image.
//  - The first result released by a pixel reaches o_res through the pixel, window,
//    sum and output registers, in that order.
//  - Throughput: one pixel per cycle while i_stall is low. A pixel past row and column 0
//    releases one result, two or four in the last column or row, and holds the window
//    until they leave, one result per cycle through the single divider stage.
//  - The line buffer is one 1024 x 96 RAM (both stored rows per column), read when a
//    pixel is accepted and written back as it enters the window; no clearing pass.
//  - image_size is written through i_cfg_valid / i_cfg_data (always ready), clamped
//    to 2..1024, and restarts the frame at pixel (0, 0). Write it only when idle.
//  - Reset (synchronous, i_rst_n low) empties the pipeline, sets image_size to 1024
//    and the position to (0, 0).
//  - When the receiver stalls, the output register holds and the stall propagates
//    back stage by stage; bubbles in the pipeline are absorbed before o_stall rises.
`default_nettype none

module box_smooth_three_by_three_top import bsm3_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire t_in_pixel         i_pix,
    output logic                   o_stall,
    output logic                   o_valid,
    output t_result                o_res,
    input  wire logic              i_stall,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [SIZE_W-1:0] i_cfg_data
);

    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_row;
    logic [ADDR_W-1:0] r_col;
    logic              r_s1_valid;
    t_stage            r_s1;

    logic              in_acc;
    logic              s1_take;
    logic [SIZE_W-1:0] size_m1;
    logic              row_last;
    logic              col_last;
    logic [SIZE_W-1:0] n_size;
    t_stage            n_s1;
    t_row_pair         rows_rd;
    t_row_pair         rows_wr;
    logic              job_valid;
    t_job              job;
    logic              job_stall;

    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_valid && !o_stall;
    assign o_stall     = r_s1_valid && !s1_take;

    assign size_m1  = r_size - SIZE_W'(1);
    assign row_last = (SIZE_W'(r_row) == size_m1);
    assign col_last = (SIZE_W'(r_col) == size_m1);

    // out-of-range sizes saturate
    always_comb begin
        if (i_cfg_data < SIZE_W'(SIZE_MIN)) begin
            n_size = SIZE_W'(SIZE_MIN);
        end else if (i_cfg_data > SIZE_W'(MAX_SIZE)) begin
            n_size = SIZE_W'(MAX_SIZE);
        end else begin
            n_size = i_cfg_data;
        end
    end

    always_comb begin
        n_s1.px.red   = i_pix.in_red;
        n_s1.px.green = i_pix.in_green;
        n_s1.px.blue  = i_pix.in_blue;
        n_s1.row      = r_row;
        n_s1.col      = r_col;
        n_s1.emits    = (r_row != '0) && (r_col != '0);
        n_s1.row_last = row_last;
        n_s1.col_last = col_last;
        n_s1.row_ge2  = (r_row >= ADDR_W'(2));
        n_s1.col_ge2  = (r_col >= ADDR_W'(2));
    end

    // raster position of the next pixel; a size write restarts the frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SIZE_W'(MAX_SIZE);
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_size <= n_size;
                r_row  <= '0;
                r_col  <= '0;
            end else if (in_acc) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_row + ADDR_W'(1);
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
            end
            r_s1_valid <= in_acc || (r_s1_valid && !s1_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= n_s1;
        end
    end

    // rows shift down one slot at the column just consumed
    always_comb begin
        rows_wr.older = rows_rd.newer;
        rows_wr.newer = r_s1.px;
    end

    bsm3_ram #(
        .WIDTH ($bits(t_row_pair)),
        .DEPTH (MAX_SIZE)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (s1_take),
        .i_waddr (r_s1.col),
        .i_wdata (rows_wr),
        .i_re    (in_acc),
        .i_raddr (r_col),
        .o_rdata (rows_rd)
    );

    bsm3_window u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s1_valid  (r_s1_valid),
        .i_s1        (r_s1),
        .i_rows      (rows_rd),
        .o_s1_take   (s1_take),
        .o_job_valid (job_valid),
        .o_job       (job),
        .i_job_stall (job_stall)
    );

    bsm3_divide u_divide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_stall (job_stall),
        .o_valid     (o_valid),
        .o_res       (o_res),
        .i_stall     (i_stall)
    );

`ifndef SYNTHESIS
    // raster position never leaves the image
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (SIZE_W'(r_col) < r_size) && (SIZE_W'(r_row) < r_size))
        else $error("raster position outside image");

    // the final pixel of a frame wraps the position to the origin
    a_frame_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && row_last && col_last && !i_cfg_valid) |=>
        (r_row == '0) && (r_col == '0))
        else $error("position did not wrap after final pixel");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/box_smooth_three_by_three_top_tb.sv =====
// Testbench for box_smooth_three_by_three_top: random and directed RGB frames, checked
// result by result against an in-bench 3x3 mean-of-in-image-neighbors predictor.
// Depends on bsm3_pkg and the box_smooth_three_by_three_top RTL.
`timescale 1ns / 1ps

import bsm3_pkg::*;

// Predicts the smoothed pixels and holds them until the block delivers them.
class mean_window_predictor;
    int unsigned size_px;                  // active image side
    int unsigned at_row, at_col;           // position of the next input pixel
    t_rgb        older_line[MAX_SIZE];     // two rows above the current one
    t_rgb        newer_line[MAX_SIZE];
    t_rgb        win[3][3];                // [row slot][column slot], slot 2 newest
    t_result     expected_means[$];
    int unsigned errors;
    int unsigned checked;

    function new();
        size_px = MAX_SIZE;
        at_row  = 0;
        at_col  = 0;
        errors  = 0;
        checked = 0;
        foreach (older_line[i]) begin
            older_line[i] = '0;
            newer_line[i] = '0;
        end
        foreach (win[i, j]) win[i][j] = '0;
    endfunction

    // A size write clamps to the legal range and restarts the frame.
    function void restart(logic [SIZE_W-1:0] value);
        if (value < SIZE_MIN)
            size_px = SIZE_MIN;
        else if (value > MAX_SIZE)
            size_px = MAX_SIZE;
        else
            size_px = value;
        at_row = 0;
        at_col = 0;
    endfunction

    // Truncated mean over window rows rlo..2 and columns clo..2.
    function t_result window_mean(int rlo, int clo, int unsigned orow, int unsigned ocol);
        int unsigned sum_r, sum_g, sum_b, cnt;
        t_result     res;
        sum_r = 0;
        sum_g = 0;
        sum_b = 0;
        for (int rs = rlo; rs < 3; rs++)
            for (int cs = clo; cs < 3; cs++) begin
                sum_r += win[rs][cs].red;
                sum_g += win[rs][cs].green;
                sum_b += win[rs][cs].blue;
            end
        cnt = (3 - rlo) * (3 - clo);
        res.out_red    = CH_W'(sum_r / cnt);
        res.out_green  = CH_W'(sum_g / cnt);
        res.out_blue   = CH_W'(sum_b / cnt);
        res.out_row    = POS_W'(orow);
        res.out_col    = POS_W'(ocol);
        res.run_last   = 1'b0;
        res.frame_done = 1'b0;
        return res;
    endfunction

    // Called on every accepted pixel transfer.
    function void note_pixel(t_in_pixel pin);
        int unsigned r, c, n;
        int          rlo, clo;
        t_rgb        px;
        t_result     batch[$];
        n = size_px;
        r = at_row;
        c = (at_col >= MAX_SIZE) ? MAX_SIZE - 1 : at_col;
        px.red   = pin.in_red;
        px.green = pin.in_green;
        px.blue  = pin.in_blue;

        for (int rs = 0; rs < 3; rs++) begin
            win[rs][0] = win[rs][1];
            win[rs][1] = win[rs][2];
        end
        win[0][2]     = older_line[c];
        win[1][2]     = newer_line[c];
        win[2][2]     = px;
        older_line[c] = newer_line[c];
        newer_line[c] = px;

        if (r >= 1 && c >= 1) begin
            rlo = (r >= 2) ? 0 : 1;
            clo = (c >= 2) ? 0 : 1;
            batch.push_back(window_mean(rlo, clo, r - 1, c - 1));
            if (c == n - 1)
                batch.push_back(window_mean(rlo, 1, r - 1, c));
            if (r == n - 1) begin
                batch.push_back(window_mean(1, clo, r, c - 1));
                if (c == n - 1)
                    batch.push_back(window_mean(1, 1, r, c));
            end
        end
        if (batch.size() > 0) begin
            batch[batch.size() - 1].run_last = 1'b1;
            if (r == n - 1 && c == n - 1)
                foreach (batch[i]) batch[i].frame_done = 1'b1;
        end
        foreach (batch[i]) expected_means.push_back(batch[i]);

        if (c + 1 >= n) begin
            at_col = 0;
            at_row = (r + 1 >= n) ? 0 : r + 1;
        end else begin
            at_col = c + 1;
        end
    endfunction

    function void cmp_field(string field, int unsigned want, int unsigned got, t_result ref_res);
        if (want != got) begin
            $display("%0t mismatch %s at (%0d,%0d): expected %0h, actual %0h",
                     $time, field, ref_res.out_row, ref_res.out_col, want, got);
            errors++;
        end
    endfunction

    // Called on every accepted result transfer.
    function void check_result(t_result got);
        t_result want;
        if (expected_means.size() == 0) begin
            $display("%0t unexpected result: expected none, actual (%0d,%0d) rgb %h %h %h",
                     $time, got.out_row, got.out_col, got.out_red, got.out_green,
                     got.out_blue);
            errors++;
            return;
        end
        want = expected_means.pop_front();
        checked++;
        cmp_field("out_red", want.out_red, got.out_red, want);
        cmp_field("out_green", want.out_green, got.out_green, want);
        cmp_field("out_blue", want.out_blue, got.out_blue, want);
        cmp_field("out_row", want.out_row, got.out_row, want);
        cmp_field("out_col", want.out_col, got.out_col, want);
        cmp_field("run_last", want.run_last, got.run_last, want);
        cmp_field("frame_done", want.frame_done, got.frame_done, want);
    endfunction
endclass

module box_smooth_three_by_three_top_tb;

    localparam int CYCLE_LIMIT = 400000;   // far above the slowest legal run
    localparam int IDLE_PCT    = 19;       // idle share per side, percent
    localparam int DRAIN_WAIT  = 8;        // exceeds the pipeline latency
    localparam int RAND_ITEMS  = 360;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              pix_valid = 1'b0;
    t_in_pixel         pix       = '0;
    logic              pix_stall;
    logic              res_valid;
    t_result           res;
    logic              res_stall = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data  = '0;

    bit                quiet = 1'b0;       // suppresses idling on both sides
    int unsigned       pixels_sent = 0;
    int unsigned       size_writes = 0;
    int unsigned       rand_items  = 0;

    mean_window_predictor predictor = new();

    box_smooth_three_by_three_top u_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (pix_valid),
        .i_pix      (pix),
        .o_stall    (pix_stall),
        .o_valid    (res_valid),
        .o_res      (res),
        .i_stall    (res_stall),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_data (cfg_data)
    );

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 0;
    end

    // Watchdog: a hung pipeline or a lost result ends here.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL box_smooth_three_by_three_top");
        $finish;
    end

    // Result side: sample the transfer with pre-edge values, then pick next stall.
    initial begin
        forever begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                predictor.check_result(res);
            res_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    function automatic logic [CH_W-1:0] rand_channel();
        int unsigned k;
        k = $urandom_range(9);
        if (k == 0)
            return '0;
        if (k == 1)
            return '1;
        return CH_W'($urandom_range(65535));
    endfunction

    function automatic t_in_pixel rand_pixel();
        t_in_pixel p;
        p.in_red   = rand_channel();
        p.in_green = rand_channel();
        p.in_blue  = rand_channel();
        return p;
    endfunction

    function automatic t_in_pixel make_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                             logic [CH_W-1:0] b);
        t_in_pixel p;
        p.in_red   = r;
        p.in_green = g;
        p.in_blue  = b;
        return p;
    endfunction

    // One pixel transfer; entered just after a rising edge, returns at the accepting edge.
    task automatic send_pixel(input t_in_pixel px);
        while (!quiet && $urandom_range(99) < IDLE_PCT) begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix       <= px;
        do @(posedge clk); while (pix_stall);
        predictor.note_pixel(px);
        pixels_sent++;
    endtask

    task automatic send_random(input int unsigned count);
        for (int unsigned i = 0; i < count; i++) send_pixel(rand_pixel());
    endtask

    // Wait for every predicted result, then let the pipeline settle.
    task automatic drain();
        pix_valid <= 1'b0;
        while (predictor.expected_means.size() > 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Size register transfer; only called with the block idle.
    task automatic write_size(input logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        predictor.restart(value);
        size_writes++;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned kind, n, frames, cnt;
        logic [SIZE_W-1:0] value;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // a few pixels at the reset size, then a write restarts the frame
        send_random(3);
        drain();
        // zero clamps to the smallest side: corners only, last pixel gives four
        write_size('0);
        repeat (4) send_pixel(make_pixel('1, '1, '1));
        // same size again without a write: frame wrapped to (0,0); truncation check
        send_pixel(make_pixel('1, '0, 16'h0001));
        send_pixel(make_pixel('0, '1, 16'h0002));
        send_pixel(make_pixel('0, '1, 16'h0000));
        send_pixel(make_pixel('1, '0, 16'h0001));
        drain();
        // 3x3: corners, edges (six) and the center (nine)
        write_size(SIZE_W'(3));
        for (int i = 0; i < 9; i++)
            send_pixel(make_pixel((i % 2) ? '1 : '0, (i % 2) ? '0 : '1,
                                  CH_W'(i * 16'h1111)));
        drain();
        // mid-frame restart: partial 5x5, then a write of one (clamps to two)
        write_size(SIZE_W'(5));
        send_random(7);
        drain();
        write_size(SIZE_W'(1));
        send_random(4);
        drain();

        // ---- largest image: above-range write clamps to the maximum ----
        // a short stretch of the top row; nothing is released there
        write_size(SIZE_W'($urandom_range(MAX_SIZE, 2047)));
        send_random(16);
        drain();

        // ---- random frames ----
        while (rand_items < RAND_ITEMS) begin
            quiet = (rand_items >= 120 && rand_items < 220);
            kind  = $urandom_range(99);
            if (kind < 70) begin
                // well-formed frames, sometimes back to back with no write
                n = $urandom_range(2, 12);
                frames = ($urandom_range(9) < 3) ? 2 : 1;
                while (n > 2 && frames * n * n > RAND_ITEMS - rand_items) n--;
                write_size(SIZE_W'(n));
                send_random(frames * n * n);
                rand_items += frames * n * n;
            end else if (kind < 85) begin
                // wild register value, short partial frame
                case ($urandom_range(3))
                    0:       value = SIZE_W'($urandom_range(1));
                    1:       value = SIZE_W'($urandom_range(MAX_SIZE + 1, 2047));
                    default: value = SIZE_W'($urandom_range(2047));
                endcase
                write_size(value);
                n   = predictor.size_px;
                cnt = (n * n - 1 < 40) ? n * n - 1 : $urandom_range(1, 40);
                send_random(cnt);
                rand_items += cnt;
            end else begin
                // frame broken off at a random point; next write restarts
                n   = $urandom_range(2, 12);
                write_size(SIZE_W'(n));
                cnt = $urandom_range(1, n * n - 1);
                send_random(cnt);
                rand_items += cnt;
            end
            drain();
        end
        quiet = 1'b0;
        drain();

        $display("covered %0d pixel transfers, %0d size writes, %0d results checked",
                 pixels_sent, size_writes, predictor.checked);
        $display("%0d mismatches, %0d results still expected", predictor.errors,
                 predictor.expected_means.size());
        if (predictor.errors == 0 && predictor.expected_means.size() == 0)
            $display("PASS box_smooth_three_by_three_top");
        else
            $display("FAIL box_smooth_three_by_three_top");
        $finish;
    end

endmodule
